// File: hdl/ymfs_pkg.sv
// Package with shared types and constants of the YMODEM file sender.
package ymfs_pkg;

  localparam int unsigned DataBlock   = 1024;
  localparam int unsigned HeaderBlock = 128;
  localparam int unsigned StoreDepth  = 1024;
  localparam int unsigned AddrW       = $clog2(StoreDepth);

  localparam logic [1:0] ModeStart   = 2'd0;
  localparam logic [1:0] ModeRx      = 2'd1;
  localparam logic [1:0] ModePayload = 2'd2;
  localparam logic [1:0] ModeTx      = 2'd3;

  localparam logic [7:0] ByteC   = 8'h43;
  localparam logic [7:0] ByteAck = 8'h06;
  localparam logic [7:0] ByteSoh = 8'h01;
  localparam logic [7:0] ByteStx = 8'h02;
  localparam logic [7:0] ByteEot = 8'h04;

  localparam logic [0:0] CfgDataTries = 1'b0;
  localparam logic [0:0] CfgEndTries  = 1'b1;

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StBusy     = 3'd1;
  localparam logic [2:0] StDone     = 3'd2;
  localparam logic [2:0] StFailHdr  = 3'd3;
  localparam logic [2:0] StFailData = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  value;
    logic [31:0] file_size;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        frame_end;
    logic        want_payload;
    logic [10:0] payload_left;
    logic [2:0]  status;
  } out_item_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// File: hdl/ymfs_if.sv
// Valid/ready channel interfaces for input and result items.
interface ymfs_in_if;
  logic                valid;
  logic                ready;
  ymfs_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ymfs_out_if;
  logic                valid;
  logic                ready;
  ymfs_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/ymfs_store.sv
// Packet byte store: one write port, one read port, registered read data.
module ymfs_store (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [ymfs_pkg::AddrW-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [ymfs_pkg::AddrW-1:0] raddr_i,
  output logic [7:0]               rdata_o
);
  import ymfs_pkg::*;

  logic [7:0] mem_q [StoreDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: hdl/ymodem_file_sender_top.sv
// Top level of the YMODEM file sender (CRC-16, 1K data packets).
// Throughput: one item per cycle, back to back, while the output is not stalled; every item gives one result.
// The result of an item is written into the output register on acceptance.
// The next data byte of a packet is prefetched from the store one
// slot ahead, so the registered store read does not slow sending.
// Reset: asynchronous, active low; the block comes up idle with tries 5 and 6.
module ymodem_file_sender_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_index_i,
  input  logic [3:0]   cfg_data_i,
  ymfs_in_if.sink      in_ch,
  ymfs_out_if.source   out_ch
);
  import ymfs_pkg::*;

  typedef enum logic [3:0] {
    PhIdle, PhWaitC1, PhLoadHdr, PhSendHdr, PhAckHdr, PhWaitC2, PhLoadData,
    PhSendData, PhAckData, PhSendEot, PhAckEot, PhSendNull, PhAckNull,
    PhDone, PhFailHdr, PhFailData
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  data_tries_q, end_tries_q;
  logic [31:0] remain_q, remain_d;
  logic [7:0]  seq_q, seq_d;
  logic [10:0] load_q, load_d, pos_q, pos_d, chunk_q, chunk_d;
  logic [15:0] crc_q, crc_d;
  logic [3:0]  tries_q, tries_d;
  logic        out_valid_q;
  out_item_t   out_q, res;

  logic        acc;
  logic [7:0]  rdata;
  logic        we;
  logic [AddrW-1:0] raddr;
  // The store output holds entry pos-3 whenever a data byte is next.
  // Read address is the entry needed at the following slot.
  logic [10:0] idx_next;

  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign out_ch.valid = out_valid_q;
  assign out_ch.payload = out_q;

  assign we = acc && in_ch.payload.mode == ModePayload &&
              (phase_q == PhLoadHdr || phase_q == PhLoadData);

  // Address: pos_d-3 after this cycle; when pos_d < 3 it does not wrap but reads entry 0.
  always_comb begin
    idx_next = (pos_d >= 11'd3) ? pos_d - 11'd3 : 11'd0;
    raddr = idx_next[AddrW-1:0];
  end

  ymfs_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (load_q[AddrW-1:0]),
    .wdata_i (in_ch.payload.value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    logic [10:0] len, need, idx;
    logic [7:0]  b, d, sq;
    logic        last, ack;
    logic [1:0]  mode;
    logic [3:0]  tinc;
    logic [31:0] rem_next;
    phase_d  = phase_q;
    remain_d = remain_q;
    seq_d    = seq_q;
    load_d   = load_q;
    pos_d    = pos_q;
    chunk_d  = chunk_q;
    crc_d    = crc_q;
    tries_d  = tries_q;
    res      = '0;
    mode     = in_ch.payload.mode;
    ack      = in_ch.payload.value == ByteAck;
    tinc     = tries_q + 4'd1;
    len = 11'd0; need = 11'd0; idx = 11'd0; b = 8'h00; d = 8'h00; sq = 8'h00;
    last = 1'b0; rem_next = 32'd0;
    if (acc) begin
      unique case (mode)
        ModeStart: begin
          remain_d = in_ch.payload.file_size;
          seq_d = 8'd1; load_d = '0; pos_d = '0; crc_d = '0; tries_d = '0;
          chunk_d = '0; phase_d = PhWaitC1;
        end
        ModeRx: begin
          rem_next = remain_q;
          if (phase_q == PhAckData && ack) rem_next = remain_q - {21'd0, chunk_q};
          case (phase_q)
            PhWaitC1: if (in_ch.payload.value == ByteC) begin
              phase_d = PhLoadHdr; load_d = '0;
            end
            PhAckHdr: phase_d = ack ? PhWaitC2 : PhFailHdr;
            PhAckData: begin
              if (ack) begin
                remain_d = rem_next;
                seq_d = seq_q + 8'd1;
              end else begin
                tries_d = tinc;
                if (data_tries_q == 4'd0 || tinc >= data_tries_q) phase_d = PhFailData;
                else begin
                  phase_d = PhSendData; pos_d = '0; crc_d = '0;
                end
              end
            end
            PhAckEot: begin
              if (ack || end_tries_q == 4'd0 || tinc >= end_tries_q) begin
                tries_d = '0; phase_d = PhSendNull; pos_d = '0; crc_d = '0;
              end else begin
                tries_d = tinc; phase_d = PhSendEot;
              end
            end
            PhAckNull: begin
              if (!ack) tries_d = tinc;
              if (ack || end_tries_q == 4'd0 || tinc >= end_tries_q) phase_d = PhDone;
              else begin
                phase_d = PhSendNull; pos_d = '0; crc_d = '0;
              end
            end
            default: ;
          endcase
          // Next chunk, or EOT when nothing remains, after the second 'C' or an acknowledged data packet.
          if ((phase_q == PhWaitC2 && in_ch.payload.value == ByteC) ||
              (phase_q == PhAckData && ack)) begin
            if (rem_next == 32'd0) begin
              phase_d = PhSendEot; tries_d = '0;
            end else begin
              chunk_d = (rem_next > DataBlock) ? 11'(DataBlock) : rem_next[10:0];
              load_d = '0; phase_d = PhLoadData;
            end
          end
        end
        ModePayload: begin
          if (phase_q == PhLoadHdr || phase_q == PhLoadData) begin
            need = (phase_q == PhLoadHdr) ? 11'(HeaderBlock) : chunk_q;
            load_d = load_q + 11'd1;
            if (load_d >= need) begin
              if (phase_q == PhLoadData) tries_d = '0;
              phase_d = (phase_q == PhLoadHdr) ? PhSendHdr : PhSendData;
              pos_d = '0; crc_d = '0;
            end
          end
        end
        ModeTx: begin
          if (phase_q == PhSendHdr || phase_q == PhSendData || phase_q == PhSendNull) begin
            len = (phase_q == PhSendData) ? 11'(DataBlock) : 11'(HeaderBlock);
            sq  = (phase_q == PhSendData) ? seq_q : 8'h00;
            idx = pos_q - 11'd3;
            if (pos_q == 11'd0) b = (phase_q == PhSendData) ? ByteStx : ByteSoh;
            else if (pos_q == 11'd1) b = sq;
            else if (pos_q == 11'd2) b = 8'hFF - sq;
            else if (pos_q < 11'd3 + len) begin
              if (phase_q == PhSendHdr || (phase_q == PhSendData && idx < chunk_q))
                d = rdata;
              crc_d = crc_byte(crc_q, d);
              b = d;
            end else if (pos_q == 11'd3 + len) b = crc_q[15:8];
            else begin
              b = crc_q[7:0]; last = 1'b1;
            end
            pos_d = pos_q + 11'd1;
            res.tx_valid = 1'b1; res.tx_byte = b; res.frame_end = last;
            if (last) begin
              phase_d = (phase_q == PhSendHdr) ? PhAckHdr :
                        (phase_q == PhSendData) ? PhAckData : PhAckNull;
            end
          end else if (phase_q == PhSendEot) begin
            res.tx_valid = 1'b1; res.tx_byte = ByteEot; res.frame_end = 1'b1;
            phase_d = PhAckEot;
          end
        end
        default: ;
      endcase
    end
    if (phase_d == PhLoadHdr) begin
      res.want_payload = 1'b1;
      res.payload_left = (11'(HeaderBlock) > load_d) ? 11'(HeaderBlock) - load_d : '0;
    end else if (phase_d == PhLoadData) begin
      res.want_payload = 1'b1;
      res.payload_left = (chunk_d > load_d) ? chunk_d - load_d : '0;
    end
    case (phase_d)
      PhIdle:     res.status = StIdle;
      PhDone:     res.status = StDone;
      PhFailHdr:  res.status = StFailHdr;
      PhFailData: res.status = StFailData;
      default:    res.status = StBusy;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      data_tries_q <= 4'd5; end_tries_q <= 4'd6;
      remain_q <= '0; seq_q <= 8'd1; load_q <= '0; pos_q <= '0;
      chunk_q <= '0; crc_q <= '0; tries_q <= '0; out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d; remain_q <= remain_d; seq_q <= seq_d;
      load_q <= load_d; pos_q <= pos_d; chunk_q <= chunk_d;
      crc_q <= crc_d; tries_q <= tries_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgDataTries: data_tries_q <= cfg_data_i;
          CfgEndTries:  end_tries_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (acc) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) out_q <= res;
  end

endmodule
